FILE: rtl/runge_kutta_stage_update_unit_assert.svh
// Assertion macros for the stage update unit
`ifndef RUNGE_KUTTA_STAGE_UPDATE_UNIT_ASSERT_SVH
`define RUNGE_KUTTA_STAGE_UPDATE_UNIT_ASSERT_SVH

// antecedent implies consequent on the next cycle
`define RKS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// antecedent implies consequent in the same cycle
`define RKS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rks_pkg.sv
`default_nettype none
package rks_pkg;
   localparam int DataWidthDefault = 32;
   localparam int FracBitsDefault  = 16;

   localparam logic [2:0] CSR_CFL_NUMBER    = 3'd0;
   localparam logic [2:0] CSR_STAGE_ALPHA   = 3'd1;
   localparam logic [2:0] CSR_STAGE_BETA    = 3'd2;
   localparam logic [2:0] CSR_TIME_ACCURATE = 3'd3;
   localparam logic [2:0] CSR_GLOBAL_STEP   = 3'd4;

   // datapath operand selection for the shared multiplier
   localparam logic [2:0] MUL_RATIO = 3'd0;
   localparam logic [2:0] MUL_ALPHA = 3'd1;
   localparam logic [2:0] MUL_RHS_A = 3'd2;
   localparam logic [2:0] MUL_BETA  = 3'd3;
   localparam logic [2:0] MUL_RHS_B = 3'd4;

   typedef struct packed {
      logic       load;       // capture item
      logic       div_start;  // start divider
      logic       div_sweep;  // divide global_step by max cfl
      logic       mul_go;     // perform one multiply step
      logic [2:0] mul_sel;
      logic       finish;     // form result
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic alpha_nz;
      logic beta_nz;
      logic time_acc;
      logic upd;
      logic last;
   } status_type;
endpackage
`default_nettype wire

FILE: rtl/rks_if.sv
`default_nettype none
interface rks_req_if #(parameter int DW = 32);
   logic valid;
   logic ready;
   logic [DW-2:0] update_coeff;
   logic [DW-2:0] cell_volume;
   logic signed [DW-1:0] current_value;
   logic signed [DW-1:0] start_value;
   logic signed [DW-1:0] accum_value;
   logic signed [DW-1:0] rhs_value;
   logic updatable;
   logic last_of_sweep;
   modport source (output valid, update_coeff, cell_volume, current_value, start_value,
                   accum_value, rhs_value, updatable, last_of_sweep, input ready);
   modport sink (input valid, update_coeff, cell_volume, current_value, start_value,
                 accum_value, rhs_value, updatable, last_of_sweep, output ready);
endinterface

interface rks_rsp_if #(parameter int DW = 32);
   logic valid;
   logic ready;
   logic signed [DW-1:0] new_value;
   logic signed [DW-1:0] new_accum;
   logic signed [DW-1:0] new_rhs;
   logic zero_speed_fault;
   logic step_too_large;
   logic sweep_done;
   logic [DW-2:0] max_cfl;
   logic [DW-2:0] max_step;
   modport source (output valid, new_value, new_accum, new_rhs, zero_speed_fault,
                   step_too_large, sweep_done, max_cfl, max_step, input ready);
   modport sink (input valid, new_value, new_accum, new_rhs, zero_speed_fault,
                 step_too_large, sweep_done, max_cfl, max_step, output ready);
endinterface
`default_nettype wire

FILE: rtl/rks_div.sv
`default_nettype none
// Radix-2 restoring divider: (n << FB) / d, saturating, one quotient bit a cycle
module rks_div import rks_pkg::*; #(
   parameter int DW = DataWidthDefault,
   parameter int FB = FracBitsDefault
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-2:0] num,
   input  wire logic [DW-2:0] den,
   output logic               busy,
   output logic [DW-2:0]      quo
);
   localparam int NW = DW - 1 + FB;
   localparam int CW = $clog2(NW + 1);
   localparam logic [DW-2:0] MaxP = '1;

   logic [NW-1:0] sh_ff, sh_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] q_ff, q_in;
   logic [DW-2:0] d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [DW-1:0] trial;

   always_comb begin
      sh_in = sh_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {rem_ff[DW-2:0], sh_ff[NW-1]};
      if (start) begin
         sh_in = {num, FB'(0)};
         rem_in = '0;
         q_in = '0;
         d_in = den;
         cnt_in = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sh_in = {sh_ff[NW-2:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            rem_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff <= sh_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign busy = busy_ff;
   always_comb begin
      if (d_ff == '0 || q_ff[NW-1:DW-1] != '0) quo = MaxP;
      else quo = q_ff[DW-2:0];
   end
endmodule
`default_nettype wire

FILE: rtl/rks_datapath.sv
`default_nettype none
module rks_datapath import rks_pkg::*; #(
   parameter int DW = DataWidthDefault,
   parameter int FB = FracBitsDefault
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cmd_type       cmd,
   output status_type         sts,
   input  wire logic          csr_write_enable,
   input  wire logic [2:0]    csr_index,
   input  wire logic [DW-1:0] csr_write_data,
   rks_req_if.sink            req,
   output logic signed [DW-1:0] o_value,
   output logic signed [DW-1:0] o_accum,
   output logic signed [DW-1:0] o_rhs,
   output logic               o_fault,
   output logic               o_big,
   output logic               o_last,
   output logic [DW-2:0]      o_max_cfl,
   output logic [DW-2:0]      o_max_step
);
   localparam logic [DW-1:0] WSign = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] WMax  = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] QOne  = (FB < DW - 1) ? (DW'(1) << FB) : WMax;

   logic [DW-2:0] cfl_ff, gstep_ff;
   logic [DW-1:0] alpha_ff, beta_ff;
   logic          tacc_ff;
   logic [DW-1:0] rmax_ff, rmax_in;

   logic [DW-2:0] coeff_ff, vol_ff;
   logic [DW-1:0] cur_ff, start_ff, acc_ff, rhs_ff;
   logic          upd_ff, last_ff;
   logic [DW-1:0] dt_ff, tmp_ff, ratio_ff, nv_ff, nr_ff;

   logic          div_start;
   logic [DW-2:0] div_num, div_den, div_q;
   logic          div_busy;

   logic [DW-1:0] ma, mb, mp_a, mp_b, mul_res;
   logic [2*DW-1:0] prod;
   logic          neg, ovf;
   logic [DW-1:0] mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfl_ff <= (DW-1)'(QOne);
         alpha_ff <= '0;
         beta_ff <= '0;
         tacc_ff <= 1'b0;
         gstep_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CFL_NUMBER:    cfl_ff <= csr_write_data[DW-2:0];
            CSR_STAGE_ALPHA:   alpha_ff <= csr_write_data;
            CSR_STAGE_BETA:    beta_ff <= csr_write_data;
            CSR_TIME_ACCURATE: tacc_ff <= csr_write_data[0];
            CSR_GLOBAL_STEP:   gstep_ff <= csr_write_data[DW-2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         coeff_ff <= req.update_coeff;
         vol_ff <= req.cell_volume;
         cur_ff <= req.current_value;
         start_ff <= req.start_value;
         acc_ff <= req.accum_value;
         rhs_ff <= req.rhs_value;
         upd_ff <= req.updatable;
         last_ff <= req.last_of_sweep;
      end
   end

   assign div_start = cmd.div_start;
   assign div_num = cmd.div_sweep ? gstep_ff : (tacc_ff ? gstep_ff : cfl_ff);
   assign div_den = cmd.div_sweep ? rmax_ff[DW-2:0] : (tacc_ff ? vol_ff : coeff_ff);

   rks_div #(.DW(DW), .FB(FB)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .busy(div_busy), .quo(div_q)
   );

   // shared saturating Q multiplier
   always_comb begin
      case (cmd.mul_sel)
         MUL_RATIO: begin mp_a = dt_ff;    mp_b = {1'b0, coeff_ff}; end
         MUL_ALPHA: begin mp_a = alpha_ff; mp_b = dt_ff; end
         MUL_RHS_A: begin mp_a = rhs_ff;   mp_b = tmp_ff; end
         MUL_BETA:  begin mp_a = beta_ff;  mp_b = dt_ff; end
         default:   begin mp_a = rhs_ff;   mp_b = tmp_ff; end
      endcase
      ma = mp_a[DW-1] ? (~mp_a + DW'(1)) : mp_a;
      mb = mp_b[DW-1] ? (~mp_b + DW'(1)) : mp_b;
      neg = mp_a[DW-1] ^ mp_b[DW-1];
      prod = {{DW{1'b0}}, ma} * {{DW{1'b0}}, mb};
      mag = prod[FB +: DW];
      ovf = (prod >> (FB + DW)) != '0;
      if (neg) mul_res = (ovf || mag > WSign) ? WSign : (~mag + DW'(1));
      else mul_res = (ovf || mag > WMax) ? WMax : mag;
   end

   function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
      logic [DW-1:0] s;
      s = a + b;
      if (a[DW-1] == b[DW-1] && s[DW-1] != a[DW-1]) return a[DW-1] ? WSign : WMax;
      return s;
   endfunction

   always_comb begin
      rmax_in = rmax_ff;
      if (cmd.mul_go && cmd.mul_sel == MUL_RATIO && upd_ff && tacc_ff
          && mul_res > QOne && mul_res > rmax_ff)
         rmax_in = mul_res;
      if (cmd.finish && last_ff) rmax_in = QOne;
   end

   always_ff @(posedge clock) begin
      if (reset) rmax_ff <= QOne;
      else rmax_ff <= rmax_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ratio_ff <= '0;
         nv_ff <= req.current_value;
         nr_ff <= req.rhs_value;
      end
      if (cmd.div_start && !cmd.div_sweep) dt_ff <= '0;
      if (!div_busy && !cmd.div_sweep && !cmd.div_start && !cmd.mul_go && !cmd.finish)
         dt_ff <= (!tacc_ff && coeff_ff == '0) ? '0 : {1'b0, div_q};
      if (cmd.mul_go) begin
         case (cmd.mul_sel)
            MUL_RATIO: ratio_ff <= mul_res;
            MUL_RHS_A: nv_ff <= sat_add(start_ff, mul_res);
            MUL_RHS_B: nr_ff <= mul_res;
            default:   tmp_ff <= mul_res;
         endcase
      end
   end

   assign o_value = nv_ff;
   assign o_rhs = nr_ff;
   assign o_accum = (upd_ff && beta_ff != '0) ? sat_add(acc_ff, nr_ff) : acc_ff;
   assign o_fault = upd_ff && !tacc_ff && coeff_ff == '0 && rhs_ff != '0;
   assign o_big = upd_ff && tacc_ff && ratio_ff > QOne;
   assign o_last = last_ff;
   assign o_max_cfl = rmax_ff[DW-2:0];
   assign o_max_step = (last_ff && tacc_ff) ? div_q : '0;

   assign sts.div_busy = div_busy;
   assign sts.alpha_nz = alpha_ff != '0;
   assign sts.beta_nz = beta_ff != '0;
   assign sts.time_acc = tacc_ff;
   assign sts.upd = upd_ff;
   assign sts.last = last_ff;
endmodule
`default_nettype wire

FILE: rtl/rks_ctrl.sv
`default_nettype none
`include "runge_kutta_stage_update_unit_assert.svh"
module rks_ctrl import rks_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   output logic      out_valid,
   input  wire logic out_ready,
   input  wire status_type sts,
   output cmd_type   cmd,
   output logic      capture
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV   = 4'd1;
   localparam logic [3:0] S_DWAIT = 4'd2;
   localparam logic [3:0] S_DTLAT = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_SWDIV = 4'd5;
   localparam logic [3:0] S_SWAIT = 4'd6;
   localparam logic [3:0] S_OUT   = 4'd7;

   logic [3:0] state_ff, state_in;
   logic [2:0] msel_ff, msel_in;
   logic       ovalid_ff, ovalid_in;

   // the output register holds the result, so the next item may be worked
   // on while it waits; only the capture itself waits for the transfer
   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = ovalid_ff;

   always_comb begin
      state_in = state_ff;
      msel_in = msel_ff;
      ovalid_in = ovalid_ff && !out_ready;
      cmd = '0;
      capture = 1'b0;
      unique case (state_ff)
         S_IDLE: if (in_valid && in_ready) begin
            cmd.load = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (sts.upd) begin
               cmd.div_start = 1'b1;
               state_in = S_DWAIT;
            end else state_in = S_SWDIV;
         end
         S_DWAIT: if (!sts.div_busy) state_in = S_DTLAT;
         S_DTLAT: begin
            // dt is latched this cycle
            msel_in = sts.time_acc ? MUL_RATIO : MUL_ALPHA;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_sel = msel_ff;
            cmd.mul_go = 1'b1;
            if ((msel_ff == MUL_ALPHA || msel_ff == MUL_RHS_A) && !sts.alpha_nz)
               cmd.mul_go = 1'b0;
            if ((msel_ff == MUL_BETA || msel_ff == MUL_RHS_B) && !sts.beta_nz)
               cmd.mul_go = 1'b0;
            if (msel_ff == MUL_RHS_B) state_in = S_SWDIV;
            else msel_in = msel_ff + 3'd1;
         end
         S_SWDIV: begin
            if (sts.last && sts.time_acc) begin
               cmd.div_start = 1'b1;
               cmd.div_sweep = 1'b1;
               state_in = S_SWAIT;
            end else state_in = S_OUT;
         end
         S_SWAIT: begin
            cmd.div_sweep = 1'b1;
            if (!sts.div_busy) state_in = S_OUT;
         end
         S_OUT: begin
            cmd.div_sweep = 1'b1;
            // hold while the previous result still waits for its transfer
            if (!ovalid_ff || out_ready) begin
               capture = 1'b1;
               ovalid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      cmd.finish = capture;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         msel_ff <= MUL_RATIO;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         msel_ff <= msel_in;
         ovalid_ff <= ovalid_in;
      end
   end

   `RKS_ASSERT_SAME(a_no_accept_busy, clock, reset, state_ff != S_IDLE, !in_ready, "accept while busy")
   `RKS_ASSERT_NEXT(a_out_after_cap, clock, reset, capture, out_valid, "result not shown")
   `RKS_ASSERT_NEXT(a_hold_rsp, clock, reset, out_valid && !out_ready, out_valid, "result dropped")
   `RKS_ASSERT_SAME(a_no_overwrite, clock, reset, capture, !out_valid || out_ready, "result overwritten")
endmodule
`default_nettype wire

FILE: rtl/runge_kutta_stage_update_unit.sv
// Sequence: an updated item runs the serial divider (DW-1+FB steps) for dt, then
//   the multiplies; a time-accurate sweep-end item runs it again for the max step.
//   A pass-through item that does not end a sweep uses neither.
// Throughput: one item at a time; the next is taken the cycle after a result is
//   registered, so the divider runs of each item set it.
// Reset: synchronous, active high; control and config registers return to defaults, max CFL 1.0.
`default_nettype none
module runge_kutta_stage_update_unit import rks_pkg::*; #(
   parameter int DW = DataWidthDefault,
   parameter int FB = FracBitsDefault
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_write_enable,
   input  wire logic [2:0]    csr_index,
   input  wire logic [DW-1:0] csr_write_data,
   rks_req_if.sink            req,
   rks_rsp_if.source          rsp
);
   cmd_type    cmd;
   status_type sts;
   logic       capture;
   logic signed [DW-1:0] v, a, r;
   logic f, b, l;
   logic [DW-2:0] mc, ms;

   rks_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .sts(sts), .cmd(cmd), .capture(capture)
   );

   rks_datapath #(.DW(DW), .FB(FB)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .req(req),
      .o_value(v), .o_accum(a), .o_rhs(r), .o_fault(f), .o_big(b), .o_last(l),
      .o_max_cfl(mc), .o_max_step(ms)
   );

   always_ff @(posedge clock) begin
      if (capture) begin
         rsp.new_value <= v;
         rsp.new_accum <= a;
         rsp.new_rhs <= r;
         rsp.zero_speed_fault <= f;
         rsp.step_too_large <= b;
         rsp.sweep_done <= l;
         rsp.max_cfl <= mc;
         rsp.max_step <= ms;
      end
   end
endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench import rks_pkg::*; ();

   localparam int DW = 32;
   localparam int FB = 16;
   localparam logic [DW-1:0] MAXP = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINN = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] ONE = 1 << FB;

   typedef struct packed {
      logic [DW-2:0] update_coeff;
      logic [DW-2:0] cell_volume;
      logic [DW-1:0] current_value;
      logic [DW-1:0] start_value;
      logic [DW-1:0] accum_value;
      logic [DW-1:0] rhs_value;
      logic updatable;
      logic last_of_sweep;
   } cell_item_type;

   typedef struct packed {
      logic [DW-1:0] new_value;
      logic [DW-1:0] new_accum;
      logic [DW-1:0] new_rhs;
      logic zero_speed_fault;
      logic step_too_large;
      logic sweep_done;
      logic [DW-2:0] max_cfl;
      logic [DW-2:0] max_step;
   } stage_result_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [2:0] csr_index = CSR_CFL_NUMBER;
   logic [DW-1:0] csr_write_data = '0;

   rks_req_if #(.DW(DW)) req_ch ();
   rks_rsp_if #(.DW(DW)) rsp_ch ();

   runge_kutta_stage_update_unit #(.DW(DW), .FB(FB)) uut (
      .clock(clock), .reset(reset), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data),
      .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [DW-1:0] cfl_reg, alpha_reg, beta_reg, gstep_reg, max_cfl_run;
   logic ta_reg;

   cell_item_type pending_cells[$];
   stage_result_type expected_results[$];
   int errors = 0;
   int results_seen = 0;
   int sweeps_seen = 0;
   int hold_off = 0;
   bit quiet_rx = 0;
   bit quiet_tx = 0;

   function automatic void add_cell(cell_item_type c);
      pending_cells.insert(pending_cells.size(), c);
   endfunction

   function automatic logic [DW-1:0] sat_mag(logic [2*DW:0] m, bit neg);
      if (neg) return (m > MINN) ? MINN : (~m[DW-1:0] + 1'b1);
      return (m > MAXP) ? MAXP : m[DW-1:0];
   endfunction

   function automatic logic [DW-1:0] fx_add(logic [DW-1:0] a, logic [DW-1:0] b);
      logic [DW-1:0] s;
      s = a + b;
      if (a[DW-1] == b[DW-1] && s[DW-1] != a[DW-1]) return a[DW-1] ? MINN : MAXP;
      return s;
   endfunction

   function automatic logic [DW-1:0] fx_mul(logic [DW-1:0] a, logic [DW-1:0] b);
      logic [DW-1:0] ma, mb;
      logic [2*DW:0] p;
      ma = a[DW-1] ? -a : a;
      mb = b[DW-1] ? -b : b;
      p = ({{(DW+1){1'b0}}, ma} * {{(DW+1){1'b0}}, mb}) >> FB;
      return sat_mag(p, a[DW-1] ^ b[DW-1]);
   endfunction

   function automatic logic [DW-1:0] fx_div(logic [DW-1:0] n, logic [DW-1:0] d);
      logic [2*DW:0] q;
      if (d == 0) return MAXP;
      q = ({{(DW+1){1'b0}}, n} << FB) / {{(DW+1){1'b0}}, d};
      return (q > MAXP) ? MAXP : q[DW-1:0];
   endfunction

   function automatic stage_result_type predict_stage(cell_item_type c);
      stage_result_type r;
      logic [DW-1:0] dt, ratio, rhs, ms;
      rhs = c.rhs_value;
      r = '0;
      r.new_value = c.current_value;
      r.new_accum = c.accum_value;
      r.new_rhs = rhs;
      if (c.updatable) begin
         if (!ta_reg) begin
            if (c.update_coeff == 0) begin
               dt = 0;
               r.zero_speed_fault = rhs != 0;
            end else begin
               dt = fx_div(cfl_reg, {1'b0, c.update_coeff});
            end
         end else begin
            dt = fx_div(gstep_reg, {1'b0, c.cell_volume});
            ratio = fx_mul(dt, {1'b0, c.update_coeff});
            if (ratio > ONE) begin
               r.step_too_large = 1;
               if (ratio > max_cfl_run) max_cfl_run = ratio;
            end
         end
         if (alpha_reg != 0)
            r.new_value = fx_add(c.start_value, fx_mul(rhs, fx_mul(alpha_reg, dt)));
         if (beta_reg != 0) begin
            r.new_rhs = fx_mul(rhs, fx_mul(beta_reg, dt));
            r.new_accum = fx_add(c.accum_value, r.new_rhs);
         end
      end
      r.max_cfl = max_cfl_run[DW-2:0];
      r.sweep_done = c.last_of_sweep;
      if (c.last_of_sweep) begin
         if (ta_reg) begin
            ms = fx_div(gstep_reg, {1'b0, max_cfl_run[DW-2:0]});
            r.max_step = ms[DW-2:0];
         end
         max_cfl_run = ONE;
      end
      return r;
   endfunction

   // driver: predicts at transfer so config is the one in force
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_results.insert(expected_results.size(),
                                    predict_stage(pending_cells.pop_front()));
         if ((!req_ch.valid || req_ch.ready) ) begin
            if (pending_cells.size() != 0 &&
                  (quiet_tx || $urandom_range(99) >= 9)) begin
               req_ch.valid <= 1;
               {req_ch.update_coeff, req_ch.cell_volume, req_ch.current_value,
                req_ch.start_value, req_ch.accum_value, req_ch.rhs_value,
                req_ch.updatable, req_ch.last_of_sweep}
                  <= pending_cells[0];
            end else begin
               req_ch.valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      stage_result_type got, exp_r;
      if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.new_value, rsp_ch.new_accum, rsp_ch.new_rhs,
                   rsp_ch.zero_speed_fault, rsp_ch.step_too_large, rsp_ch.sweep_done,
                   rsp_ch.max_cfl, rsp_ch.max_step};
            results_seen++;
            if (got.sweep_done) sweeps_seen++;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               errors++;
            end else begin
               exp_r = expected_results.pop_front();
               if (got.new_value !== exp_r.new_value)
                  $display("%0t: new_value exp %h got %h", $time, exp_r.new_value, got.new_value);
               if (got.new_accum !== exp_r.new_accum)
                  $display("%0t: new_accum exp %h got %h", $time, exp_r.new_accum, got.new_accum);
               if (got.new_rhs !== exp_r.new_rhs)
                  $display("%0t: new_rhs exp %h got %h", $time, exp_r.new_rhs, got.new_rhs);
               if (got.zero_speed_fault !== exp_r.zero_speed_fault)
                  $display("%0t: zero_speed_fault exp %b got %b", $time,
                           exp_r.zero_speed_fault, got.zero_speed_fault);
               if (got.step_too_large !== exp_r.step_too_large)
                  $display("%0t: step_too_large exp %b got %b", $time,
                           exp_r.step_too_large, got.step_too_large);
               if (got.sweep_done !== exp_r.sweep_done)
                  $display("%0t: sweep_done exp %b got %b", $time,
                           exp_r.sweep_done, got.sweep_done);
               if (got.max_cfl !== exp_r.max_cfl)
                  $display("%0t: max_cfl exp %h got %h", $time, exp_r.max_cfl, got.max_cfl);
               if (got.max_step !== exp_r.max_step)
                  $display("%0t: max_step exp %h got %h", $time, exp_r.max_step, got.max_step);
               if (got !== exp_r) errors++;
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ch.ready <= 0;
         end else begin
            rsp_ch.ready <= quiet_rx || $urandom_range(99) >= 9;
         end
      end
   end

   initial begin
      req_ch.valid = 0;
      req_ch.update_coeff = '0;
      req_ch.cell_volume = '0;
      req_ch.current_value = '0;
      req_ch.start_value = '0;
      req_ch.accum_value = '0;
      req_ch.rhs_value = '0;
      req_ch.updatable = 0;
      req_ch.last_of_sweep = 0;
      rsp_ch.ready = 0;
   end

   task automatic write_csr(logic [2:0] idx, logic [DW-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      case (idx)
         CSR_CFL_NUMBER:    cfl_reg = val & MAXP;
         CSR_STAGE_ALPHA:   alpha_reg = val;
         CSR_STAGE_BETA:    beta_reg = val;
         CSR_TIME_ACCURATE: ta_reg = val[0];
         CSR_GLOBAL_STEP:   gstep_reg = val & MAXP;
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic drain();
      while (pending_cells.size() != 0 || expected_results.size() != 0 || req_ch.valid)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [DW-1:0] rnd_word();
      case ($urandom_range(7))
         0: return MAXP;
         1: return MINN;
         2: return '0;
         3: return $urandom_range(1 << 20) - (1 << 19);
         default: return $urandom;
      endcase
   endfunction

   // random cell; small coefficients/volumes give interesting step sizes
   function automatic cell_item_type rnd_cell(bit last);
      cell_item_type c;
      c.update_coeff = (DW-1)'(($urandom_range(9) == 0) ? 0 :
                       ($urandom_range(5) == 0) ? $urandom : $urandom_range(1 << 19));
      c.cell_volume = (DW-1)'(($urandom_range(9) == 0) ? 0 :
                      ($urandom_range(5) == 0) ? $urandom : $urandom_range(1 << 19));
      c.current_value = rnd_word();
      c.start_value = rnd_word();
      c.accum_value = rnd_word();
      c.rhs_value = ($urandom_range(7) == 0) ? '0 : rnd_word();
      c.updatable = $urandom_range(7) != 0;
      c.last_of_sweep = last;
      return c;
   endfunction

   task automatic random_config();
      write_csr(CSR_CFL_NUMBER, $urandom_range(3) == 0 ? $urandom : $urandom_range(4 << FB));
      write_csr(CSR_STAGE_ALPHA, $urandom_range(5) == 0 ? '0 :
                $urandom_range(3) == 0 ? rnd_word() : $urandom_range(2 << FB) - (1 << FB));
      write_csr(CSR_STAGE_BETA, $urandom_range(5) == 0 ? '0 :
                $urandom_range(3) == 0 ? rnd_word() : $urandom_range(2 << FB) - (1 << FB));
      write_csr(CSR_TIME_ACCURATE, $urandom_range(1));
      write_csr(CSR_GLOBAL_STEP, $urandom_range(3) == 0 ? $urandom : $urandom_range(4 << FB));
   endtask

   initial begin
      cell_item_type c;
      int n;
      cfl_reg = ONE; alpha_reg = 0; beta_reg = 0; ta_reg = 0; gstep_reg = 0;
      max_cfl_run = ONE;
      repeat (3) @(posedge clock);
      reset <= 0;
      repeat (2) @(posedge clock);

      // reset defaults: everything passes or steps with zero coefficients
      add_cell('{1 << FB, 1 << FB, 5, 6, 7, 8, 1, 0});
      add_cell('{0, 0, 1, 2, 3, 9, 1, 1});
      drain();

      // steady extremes
      write_csr(CSR_CFL_NUMBER, MAXP);
      write_csr(CSR_STAGE_ALPHA, MAXP);
      write_csr(CSR_STAGE_BETA, MINN);
      add_cell('{1, 1, MAXP, MINN, MAXP, MAXP, 1, 0});
      add_cell('{MAXP, MAXP, MINN, MAXP, MINN, MINN, 1, 0});
      add_cell('{0, 0, 1, 2, 3, 1, 1, 0});   // zero coefficient fault
      add_cell('{0, 0, 1, 2, 3, 0, 1, 0});   // zero coeff, zero rhs
      add_cell('{5, 5, MAXP, MINN, 0, 4, 0, 0}); // pass-through
      add_cell('{3, 0, 1, 1, 1, 1, 0, 1});   // sweep end, not updatable
      drain();

      // time-accurate: zero volume, big ratios, sweep end
      write_csr(CSR_TIME_ACCURATE, 1);
      write_csr(CSR_GLOBAL_STEP, MAXP);
      write_csr(CSR_CFL_NUMBER, 0);
      write_csr(CSR_STAGE_ALPHA, ONE);
      write_csr(CSR_STAGE_BETA, ONE >> 1);
      add_cell('{0, 0, 1, 2, 3, 4, 1, 0});
      add_cell('{ONE, 0, 1, 2, 3, 4, 1, 0});
      add_cell('{MAXP, MAXP, MINN, MINN, MINN, MINN, 1, 0});
      add_cell('{3 << FB, MAXP, 1, 2, 3, 4, 1, 1});
      add_cell('{1, 1, 0, 0, 0, 0, 0, 1});
      drain();
      write_csr(CSR_GLOBAL_STEP, 2 << FB);
      add_cell('{3 << FB, 1 << FB, 10, 20, 30, 40, 1, 0});
      add_cell('{5 << FB, 1 << FB, 10, 20, 30, -40, 1, 0});
      add_cell('{1 << FB, 4 << FB, 10, 20, 30, 40, 1, 1});
      drain();

      // random phases; the first one runs with no idling on either side
      n = 0;
      for (int ph = 0; ph < 14; ph++) begin
         random_config();
         quiet_tx = (ph == 0);
         quiet_rx = (ph == 0);
         if (ph == 3) hold_off = 400; // back up the block
         for (int k = 0; k < 32; k++) begin
            c = rnd_cell(($urandom_range(7) == 0) || k == 31);
            add_cell(c);
            n++;
            if (ph == 5 && k == 15) begin
               // sender pause until every result is back
               while (pending_cells.size() != 0 || expected_results.size() != 0 ||
                      req_ch.valid)
                  @(posedge clock);
            end
         end
         drain();
      end
      quiet_tx = 0;
      quiet_rx = 0;
      $display("covered %0d results over %0d sweeps, steady and time-accurate modes,",
               results_seen, sweeps_seen);
      $display("saturation extremes, zero divisors, pass-through and back-pressure");
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
